[design/icv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package icv_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;
  localparam int unsigned FIFO_DEPTH     = 8;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned DIM_W   = 11;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned KERN_W  = 48;
  localparam int unsigned PROD_W  = 25;
  localparam int unsigned COL_W   = 27;
  localparam int unsigned ACC_W   = 29;

  localparam int unsigned APB_AW = 6;
  localparam int unsigned APB_DW = 64;

  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_KERNEL_LEFT   = 3'd2;
  localparam logic [2:0] REG_KERNEL_MIDDLE = 3'd3;
  localparam logic [2:0] REG_KERNEL_RIGHT  = 3'd4;

  localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

  typedef logic [2:0][KERN_W-1:0] kern_t;
  typedef logic [8:0][PIX_W-1:0]  win_t;

  typedef struct packed {
    logic               valid;
    logic               emit;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               done;
  } tag_t;

  typedef struct packed {
    logic [PIX_W-1:0]   result_pixel;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic               frame_done;
  } res_t;

endpackage

`default_nettype wire

[design/icv_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface icv_pix_if;
  logic                     valid;
  logic                     ready;
  logic [icv_pkg::PIX_W-1:0] pixel;
  logic                     frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface icv_res_if;
  logic                       valid;
  logic                       ready;
  logic [icv_pkg::PIX_W-1:0]   result_pixel;
  logic [icv_pkg::COORD_W-1:0] out_x;
  logic [icv_pkg::COORD_W-1:0] out_y;
  logic                       frame_done;

  modport source (output valid, output result_pixel, output out_x, output out_y,
                  output frame_done, input ready);
  modport sink (input valid, input result_pixel, input out_x, input out_y,
                input frame_done, output ready);
endinterface

`default_nettype wire

[design/icv_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module icv_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

[design/icv_window.sv]
`timescale 1ns / 1ps
`default_nettype none

module icv_window #(
  parameter int unsigned MAX_WIDTH  = icv_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = icv_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        acc_i,
  input  wire logic [icv_pkg::PIX_W-1:0]   pixel_i,
  input  wire logic                        frame_start_i,
  input  wire logic [icv_pkg::DIM_W-1:0]   width_cfg_i,
  input  wire logic [icv_pkg::DIM_W-1:0]   height_cfg_i,
  output icv_pkg::tag_t                    tag_o,
  output icv_pkg::win_t                    win_o
);

  localparam int unsigned AW  = $clog2(MAX_WIDTH);
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned LSW = 2 * icv_pkg::PIX_W;

  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic [AW-1:0] col_q, col_d, c0, c;
  logic [RW-1:0] row_q, row_d, r0, r;
  logic [HW-1:0] r1, rn;
  logic [WW-1:0] cn;
  logic          wrap_c;

  icv_pkg::tag_t             tag_d;
  icv_pkg::tag_t             s1_tag_q;
  logic [icv_pkg::PIX_W-1:0] s1_pix_q;
  logic [AW-1:0]             s1_addr_q;
  logic                      fwd_q, fwd_d;
  logic [LSW-1:0]            fwd_data_q;
  logic [LSW-1:0]            rd_data, pair, wr_data;
  logic [icv_pkg::PIX_W-1:0] top, mid;
  icv_pkg::tag_t             s2_tag_q;
  icv_pkg::win_t             win_q;

  always_comb begin
    if (32'(width_cfg_i) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else if (width_cfg_i < 11'd3) begin
      w = WW'(3);
    end else begin
      w = WW'(width_cfg_i);
    end
    if (32'(height_cfg_i) > MAX_HEIGHT) begin
      h = HW'(MAX_HEIGHT);
    end else if (height_cfg_i < 11'd3) begin
      h = HW'(3);
    end else begin
      h = HW'(height_cfg_i);
    end
  end

  always_comb begin
    c0     = frame_start_i ? '0 : col_q;
    r0     = frame_start_i ? '0 : row_q;
    wrap_c = WW'(c0) >= w;
    c      = wrap_c ? '0 : c0;
    r1     = wrap_c ? HW'(r0) + HW'(1) : HW'(r0);
    r      = (r1 >= h) ? '0 : RW'(r1);
    cn     = WW'(c) + WW'(1);
    rn     = HW'(r) + HW'(1);
    if (cn >= w) begin
      col_d = '0;
      row_d = (rn >= h) ? '0 : RW'(rn);
    end else begin
      col_d = AW'(cn);
      row_d = r;
    end
    tag_d.valid = 1'b1;
    tag_d.emit  = (WW'(c) >= WW'(2)) && (HW'(r) >= HW'(2));
    tag_d.x     = icv_pkg::COORD_W'(c - AW'(1));
    tag_d.y     = icv_pkg::COORD_W'(r - RW'(1));
    tag_d.done  = (WW'(c) == w - WW'(1)) && (HW'(r) == h - HW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  icv_ram #(
    .WIDTH (LSW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i     (clk_i),
    .wr_en_i   (s1_tag_q.valid),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (wr_data),
    .rd_en_i   (acc_i),
    .rd_addr_i (c),
    .rd_data_o (rd_data)
  );

  // forward the entry written by the previous beat when both hit the same column
  assign fwd_d   = s1_tag_q.valid && (s1_addr_q == c);
  assign pair    = fwd_q ? fwd_data_q : rd_data;
  assign top     = pair[LSW-1:icv_pkg::PIX_W];
  assign mid     = pair[icv_pkg::PIX_W-1:0];
  assign wr_data = {mid, s1_pix_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q <= '0;
      fwd_q    <= 1'b0;
    end else begin
      s1_tag_q       <= acc_i ? tag_d : '0;
      fwd_q          <= acc_i && fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_pix_q   <= pixel_i;
      s1_addr_q  <= c;
      fwd_data_q <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_tag_q <= '0;
      win_q    <= '0;
    end else begin
      s2_tag_q <= s1_tag_q;
      if (s1_tag_q.valid) begin
        win_q <= {s1_pix_q, mid, top, win_q[8:3]};
      end
    end
  end

  assign tag_o = s2_tag_q;
  assign win_o = win_q;

endmodule

`default_nettype wire

[design/icv_mac.sv]
`timescale 1ns / 1ps
`default_nettype none

module icv_mac (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire icv_pkg::tag_t             tag_i,
  input  wire icv_pkg::win_t             win_i,
  input  wire icv_pkg::kern_t            kern_i,
  output icv_pkg::tag_t                  tag_o,
  output logic [icv_pkg::PIX_W-1:0]      pix_o
);

  logic signed [icv_pkg::PROD_W-1:0] prod_d [9];
  logic signed [icv_pkg::PROD_W-1:0] prod_q [9];
  logic signed [icv_pkg::COL_W-1:0]  col_d  [3];
  logic signed [icv_pkg::COL_W-1:0]  col_q  [3];
  logic signed [icv_pkg::ACC_W-1:0]  acc;
  logic [icv_pkg::PIX_W-1:0]         sat;
  icv_pkg::tag_t                     s3_tag_q, s4_tag_q, s5_tag_q;
  logic [icv_pkg::PIX_W-1:0]         pix_q;

  always_comb begin
    for (int dx = 0; dx < 3; dx++) begin
      for (int dy = 0; dy < 3; dy++) begin
        prod_d[dx*3+dy] = $signed(kern_i[dx][icv_pkg::COEF_W*dy +: icv_pkg::COEF_W])
                        * $signed({1'b0, win_i[dx*3+dy]});
      end
    end
  end

  always_comb begin
    for (int dx = 0; dx < 3; dx++) begin
      col_d[dx] = icv_pkg::COL_W'(prod_q[dx*3]) + icv_pkg::COL_W'(prod_q[dx*3+1])
                + icv_pkg::COL_W'(prod_q[dx*3+2]);
    end
  end

  always_comb begin
    acc = icv_pkg::ACC_W'(col_q[0]) + icv_pkg::ACC_W'(col_q[1])
        + icv_pkg::ACC_W'(col_q[2]);
    if (acc[icv_pkg::ACC_W-1]) begin
      sat = '0;
    end else if (acc[icv_pkg::ACC_W-2:16] != '0) begin
      sat = '1;
    end else begin
      sat = acc[15:8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_tag_q <= '0;
      s4_tag_q <= '0;
      s5_tag_q <= '0;
    end else begin
      s3_tag_q <= tag_i;
      s4_tag_q <= s3_tag_q;
      s5_tag_q <= s4_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    col_q  <= col_d;
    pix_q  <= sat;
  end

  assign tag_o = s5_tag_q;
  assign pix_o = pix_q;

endmodule

`default_nettype wire

[design/icv_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module icv_fifo #(
  parameter int unsigned DEPTH = icv_pkg::FIFO_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire icv_pkg::res_t data_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output icv_pkg::res_t      data_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  icv_pkg::res_t mem_q [DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;
  logic          pop;

  assign valid_o = cnt_q != '0;
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
      end
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[design/image_convolution_3x3_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake     payload
// pix_i     in   valid/ready   pixel, frame_start
// res_o     out  valid/ready   result_pixel, out_x, out_y, frame_done
// apb       in   psel/penable  paddr[5:3] register index, pwdata, prdata
//
// One pixel beat per cycle unless pix_i.ready is low; the line-store RAM is
// read on accept and written back in the next cycle, with a bypass when two
// beats hit the same column. A result goes through the window and MAC
// registers and the output queue to res_o. Reset clears counters, window,
// config and the output queue; the line store is not cleared. res_o stalls
// back up into pix_i only when the queue and pipeline hold FIFO_DEPTH beats.
module image_convolution_3x3_unit #(
  parameter int unsigned MAX_WIDTH  = icv_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = icv_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  icv_pix_if.sink                          pix_i,
  icv_res_if.source                        res_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [icv_pkg::APB_AW-1:0]  paddr,
  input  wire logic [icv_pkg::APB_DW-1:0]  pwdata,
  output logic      [icv_pkg::APB_DW-1:0]  prdata,
  output logic                             pready
);

  localparam int unsigned CRW = $clog2(icv_pkg::FIFO_DEPTH + 1);

  logic [icv_pkg::DIM_W-1:0] width_q, height_q;
  icv_pkg::kern_t            kern_q;
  logic [2:0]                reg_idx;
  logic                      wr_en;

  logic          acc, ready;
  logic [CRW-1:0] cnt_q;
  logic          push, drop, pop;

  icv_pkg::tag_t             win_tag, mac_tag;
  icv_pkg::win_t             win;
  logic [icv_pkg::PIX_W-1:0] mac_pix;
  icv_pkg::res_t             push_data, out_data;
  logic                      out_valid;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= icv_pkg::DIM_RESET;
      height_q <= icv_pkg::DIM_RESET;
      kern_q   <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        icv_pkg::REG_IMAGE_WIDTH:   width_q   <= pwdata[icv_pkg::DIM_W-1:0];
        icv_pkg::REG_IMAGE_HEIGHT:  height_q  <= pwdata[icv_pkg::DIM_W-1:0];
        icv_pkg::REG_KERNEL_LEFT:   kern_q[0] <= pwdata[icv_pkg::KERN_W-1:0];
        icv_pkg::REG_KERNEL_MIDDLE: kern_q[1] <= pwdata[icv_pkg::KERN_W-1:0];
        icv_pkg::REG_KERNEL_RIGHT:  kern_q[2] <= pwdata[icv_pkg::KERN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      icv_pkg::REG_IMAGE_WIDTH:   prdata = icv_pkg::APB_DW'(width_q);
      icv_pkg::REG_IMAGE_HEIGHT:  prdata = icv_pkg::APB_DW'(height_q);
      icv_pkg::REG_KERNEL_LEFT:   prdata = icv_pkg::APB_DW'(kern_q[0]);
      icv_pkg::REG_KERNEL_MIDDLE: prdata = icv_pkg::APB_DW'(kern_q[1]);
      icv_pkg::REG_KERNEL_RIGHT:  prdata = icv_pkg::APB_DW'(kern_q[2]);
      default:                    prdata = '0;
    endcase
  end

  // count beats in flight or queued; hold input when the queue could overflow
  assign ready       = cnt_q < CRW'(icv_pkg::FIFO_DEPTH);
  assign pix_i.ready = ready;
  assign acc         = pix_i.valid && ready;
  assign push        = mac_tag.valid && mac_tag.emit;
  assign drop        = mac_tag.valid && !mac_tag.emit;
  assign pop         = out_valid && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + CRW'(acc) - CRW'(drop) - CRW'(pop);
    end
  end

  icv_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .acc_i         (acc),
    .pixel_i       (pix_i.pixel),
    .frame_start_i (pix_i.frame_start),
    .width_cfg_i   (width_q),
    .height_cfg_i  (height_q),
    .tag_o         (win_tag),
    .win_o         (win)
  );

  icv_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (win_tag),
    .win_i  (win),
    .kern_i (kern_q),
    .tag_o  (mac_tag),
    .pix_o  (mac_pix)
  );

  assign push_data.result_pixel = mac_pix;
  assign push_data.out_x        = mac_tag.x;
  assign push_data.out_y        = mac_tag.y;
  assign push_data.frame_done   = mac_tag.done;

  icv_fifo #(
    .DEPTH (icv_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .valid_o (out_valid),
    .ready_i (res_o.ready),
    .data_o  (out_data)
  );

  assign res_o.valid        = out_valid;
  assign res_o.result_pixel = out_data.result_pixel;
  assign res_o.out_x        = out_data.out_x;
  assign res_o.out_y        = out_data.out_y;
  assign res_o.frame_done   = out_data.frame_done;

endmodule

`default_nettype wire
